>>> hdl/pid_controller_step_top_defines.svh
// ----------------------------------------------------------------------------
// PID controller step: assertion macros
// Shared concurrent assertion forms for the controller modules.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_STEP_TOP_DEFINES_SVH
`define PID_CONTROLLER_STEP_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define PIDC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller step: shared definitions
// Widths, register indexes, reset values and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int ACC_WIDTH  = 48;
  localparam int OUT_W      = 32;
  localparam int GAIN_W     = 32;
  localparam int DT_W       = 32;
  localparam int INV_W      = 32;
  localparam int DT_FRAC    = 32;
  localparam int INV_FRAC   = 16;
  localparam int OUT_FRAC   = 16;

  localparam int DIFF_W  = DATA_WIDTH + 1;
  localparam int RATE_W  = DIFF_W + INV_W - INV_FRAC;
  localparam int MULT_W  = GAIN_W + 1;
  localparam int CNT_W   = $clog2(MULT_W);
  localparam int SUM_A   = ACC_WIDTH + DT_FRAC;
  localparam int SUM_B   = GAIN_W + RATE_W;
  localparam int SUM_W   = ((SUM_A > SUM_B) ? SUM_A : SUM_B) + 2;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [DT_W-1:0]  STEP_TIME_RST = DT_W'(4294967);
  localparam logic [INV_W-1:0] INV_STEP_RST  = INV_W'(65536000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP  = 3'd0,
    REG_INTEG = 3'd1,
    REG_DERIV = 3'd2,
    REG_STEP  = 3'd3,
    REG_INV   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_INTEG,
    OP_RATE,
    OP_PROP,
    OP_INTGAIN,
    OP_DERIV
  } op_t;

  typedef struct packed {
    logic start;
    logic acc_load;
  } mac_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_stat_t;

endpackage

>>> hdl/pidc_serial_mac.sv
// ----------------------------------------------------------------------------
// PID controller step: bit-serial multiply-accumulate unit
// Shifts the multiplier out one bit per cycle and adds the shifted
// multiplicand into a wide accumulator; the sign bit subtracts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pid_controller_step_top_defines.svh"

module pidc_serial_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  pidc_pkg::mac_cmd_t                cmd,
  input  logic signed [pidc_pkg::SUM_W-1:0] mcand,
  input  logic [pidc_pkg::MULT_W-1:0]       mplier,
  input  logic signed [pidc_pkg::SUM_W-1:0] acc_init,
  output pidc_pkg::mac_stat_t               stat,
  output logic signed [pidc_pkg::SUM_W-1:0] acc
);

  import pidc_pkg::*;

  logic [SUM_W-1:0]  mcand_sr;
  logic [MULT_W-1:0] mplier_sr;
  logic [CNT_W-1:0]  count;
  logic              busy;
  logic              done;
  logic              last;
  logic [SUM_W-1:0]  addend;
  logic [SUM_W-1:0]  acc_next;

  always_comb begin
    last     = (count == '0);
    addend   = last ? ~mcand_sr : mcand_sr;
    acc_next = acc;
    if (mplier_sr[0]) begin
      acc_next = acc + addend + SUM_W'(last);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(MULT_W - 1);
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else if (busy) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mcand_sr  <= mcand;
      mplier_sr <= mplier;
      if (cmd.acc_load) begin
        acc <= acc_init;
      end
    end else if (busy) begin
      mcand_sr  <= mcand_sr << 1;
      mplier_sr <= mplier_sr >> 1;
      acc       <= acc_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  `PIDC_ASSERT_SAME(a_done_after_busy, clk, rst, done, $past(busy), "done without a pass")
  `PIDC_ASSERT_NEXT(a_busy_holds, clk, rst, busy && !last && !cmd.start, busy, "pass cut short")
  `PIDC_ASSERT_NEXT(a_start_busy, clk, rst, cmd.start, busy, "start did not begin a pass")

endmodule

>>> hdl/pid_controller_step_top.sv
// ----------------------------------------------------------------------------
// PID controller step: top level
// Discrete PID step in fixed point with a saturating integral, a derivative
// through the configured reciprocal of the step time, and a saturated output.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  error_in
//   output   out        out_valid/ out_stall drive_out, saturated
//   config   in         cfg_valid/ cfg_ready cfg_index, cfg_data
//
// Each word runs five products through one bit-serial multiplier, each as
// an issue, a pass over the 33 multiplier bits and a writeback, and the next
// word is accepted only after the current word has left its final step.
// Reset is synchronous and restores the register defaults and clears state.
// A result stalled at the output holds; the next word is taken meanwhile and
// waits at its final step until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pid_controller_step_top_defines.svh"

module pid_controller_step_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pidc_pkg::DATA_WIDTH-1:0] error_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pidc_pkg::OUT_W-1:0]     drive_out,
  output logic                                  saturated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pidc_pkg::CFG_W-1:0]            cfg_data
);

  import pidc_pkg::*;

  logic signed [GAIN_W-1:0]     prop_gain;
  logic signed [GAIN_W-1:0]     integ_gain;
  logic signed [GAIN_W-1:0]     deriv_gain;
  logic [DT_W-1:0]              step_time;
  logic [INV_W-1:0]             inverse_step;

  state_t                       state;
  state_t                       state_next;
  op_t                          op;
  op_t                          op_next;

  logic signed [DATA_WIDTH-1:0] e_reg;
  logic signed [DATA_WIDTH-1:0] last_error;
  logic signed [ACC_WIDTH-1:0]  integral;
  logic signed [RATE_W-1:0]     rate;
  logic signed [DATA_WIDTH-1:0] drive;
  logic                         flag;

  logic signed [DIFF_W-1:0]     diff;
  logic signed [SUM_A-1:0]      integ_shifted;
  mac_cmd_t                     mac_cmd;
  mac_stat_t                    mac_stat;
  logic signed [SUM_W-1:0]      mcand;
  logic [MULT_W-1:0]            mplier;
  logic signed [SUM_W-1:0]      acc_init;
  logic signed [SUM_W-1:0]      acc;

  logic [SUM_W-SUM_A:0]         integ_hi;
  logic                         integ_ovf;
  logic signed [ACC_WIDTH-1:0]  integ_sat;
  logic [SUM_W-DATA_WIDTH-OUT_FRAC:0] drive_hi;
  logic                         drive_ovf;
  logic signed [DATA_WIDTH-1:0] drive_sat;
  logic                         out_free;

  assign cfg_ready = !rst;
  assign in_stall  = rst || (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= '0;
      integ_gain   <= '0;
      deriv_gain   <= '0;
      step_time    <= STEP_TIME_RST;
      inverse_step <= INV_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP:  prop_gain    <= GAIN_W'(cfg_data);
        REG_INTEG: integ_gain   <= GAIN_W'(cfg_data);
        REG_DERIV: deriv_gain   <= GAIN_W'(cfg_data);
        REG_STEP:  step_time    <= DT_W'(cfg_data);
        REG_INV:   inverse_step <= INV_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    diff          = DIFF_W'(e_reg) - DIFF_W'(last_error);
    integ_shifted = {integral, {DT_FRAC{1'b0}}};
    mac_cmd.start    = (state == ST_ISSUE);
    mac_cmd.acc_load = (op inside {OP_INTEG, OP_RATE, OP_PROP});
    acc_init = (op == OP_INTEG) ? SUM_W'(integ_shifted) : '0;
    case (op)
      OP_INTEG: begin
        mcand  = SUM_W'(e_reg);
        mplier = {1'b0, step_time};
      end
      OP_RATE: begin
        mcand  = SUM_W'(diff);
        mplier = {1'b0, inverse_step};
      end
      OP_PROP: begin
        mcand  = SUM_W'(e_reg);
        mplier = {prop_gain[GAIN_W-1], prop_gain};
      end
      OP_INTGAIN: begin
        mcand  = SUM_W'(integral);
        mplier = {integ_gain[GAIN_W-1], integ_gain};
      end
      default: begin
        mcand  = SUM_W'(rate);
        mplier = {deriv_gain[GAIN_W-1], deriv_gain};
      end
    endcase
  end

  pidc_serial_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .cmd      (mac_cmd),
    .mcand    (mcand),
    .mplier   (mplier),
    .acc_init (acc_init),
    .stat     (mac_stat),
    .acc      (acc)
  );

  always_comb begin
    integ_hi  = acc[SUM_W-1:SUM_A-1];
    integ_ovf = (|integ_hi) && !(&integ_hi);
    if (integ_ovf) begin
      integ_sat = acc[SUM_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                               : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      integ_sat = acc[SUM_A-1:DT_FRAC];
    end
    drive_hi  = acc[SUM_W-1:DATA_WIDTH+OUT_FRAC-1];
    drive_ovf = (|drive_hi) && !(&drive_hi);
    if (drive_ovf) begin
      drive_sat = acc[SUM_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                               : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else begin
      drive_sat = acc[DATA_WIDTH+OUT_FRAC-1:OUT_FRAC];
    end
  end

  always_comb begin
    case (op)
      OP_INTEG:   op_next = OP_RATE;
      OP_RATE:    op_next = OP_PROP;
      OP_PROP:    op_next = OP_INTGAIN;
      OP_INTGAIN: op_next = OP_DERIV;
      default:    op_next = OP_INTEG;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: state_next = ST_WAIT;
      ST_WAIT: begin
        if (mac_stat.done) begin
          state_next = (op == OP_DERIV) ? ST_OUT : ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op         <= OP_INTEG;
      integral   <= '0;
      last_error <= '0;
      flag       <= 1'b0;
    end else if (state == ST_IDLE && in_valid) begin
      op   <= OP_INTEG;
      flag <= 1'b0;
    end else if (state == ST_WAIT && mac_stat.done) begin
      op <= op_next;
      case (op)
        OP_INTEG: begin
          integral <= integ_sat;
          flag     <= flag | integ_ovf;
        end
        OP_RATE:  last_error <= e_reg;
        OP_DERIV: flag <= flag | drive_ovf;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      e_reg <= error_in;
    end
    if (state == ST_WAIT && mac_stat.done) begin
      if (op == OP_RATE) begin
        rate <= acc[RATE_W+INV_FRAC-1:INV_FRAC];
      end
      if (op == OP_DERIV) begin
        drive <= drive_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      drive_out <= OUT_W'(drive);
      saturated <= flag;
    end
  end

  `PIDC_ASSERT_NEXT(a_accept_stalls, clk, rst, in_valid && !in_stall, in_stall, "no stall after accept")
  `PIDC_ASSERT_SAME(a_done_in_wait, clk, rst, mac_stat.done, state == ST_WAIT, "stray multiply done")
  `PIDC_ASSERT_SAME(a_issue_mac_idle, clk, rst, state == ST_ISSUE, !mac_stat.busy, "multiplier busy at issue")
  `PIDC_ASSERT_SAME(a_out_from_finish, clk, rst, $rose(out_valid), $past(state) == ST_OUT, "word out of sequence")

endmodule

>>> dv/pid_controller_step_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller step: testbench
// Drives error words through the controller under many gain and step-time
// settings, with random input idle and output stall bursts. A checker
// class keeps its own copy of the controller state and registers, predicts
// each drive word and compares it with what the block returns.
// ----------------------------------------------------------------------------

module pid_controller_step_top_tb;
  import pidc_pkg::*;

  localparam int QUIET_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 200;
  localparam int TOTAL_WORDS     = 620;
  localparam int CALM_WORDS      = 120;
  localparam int FIRST_SPARE_IDX = int'(REG_INV) + 1;
  localparam int ERR_SPAN        = 1 << 20;
  localparam int GAIN_SPAN       = 1 << 18;

  localparam logic signed [DATA_WIDTH-1:0] ERR_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] ERR_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(32'h0001_0000);
  localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] drive;
    logic                    clip;
  } drive_word_t;

  class drive_checker;
    logic signed [GAIN_W-1:0]     kp, ki, kd;
    logic [DT_W-1:0]              dt;
    logic [INV_W-1:0]             inv;
    logic signed [ACC_WIDTH-1:0]  integ;
    logic signed [DATA_WIDTH-1:0] prev_err;
    drive_word_t                  pending_drive[$];
    bit                           hit_now;
    int                           fails;
    int                           checked;
    int                           clipped;

    function new();
      kp = '0;
      ki = '0;
      kd = '0;
      dt = STEP_TIME_RST;
      inv = INV_STEP_RST;
      integ = '0;
      prev_err = '0;
      fails = 0;
      checked = 0;
      clipped = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_PROP:  kp = data;
        REG_INTEG: ki = data;
        REG_DERIV: kd = data;
        REG_STEP:  dt = data;
        REG_INV:   inv = data;
        default: ;
      endcase
    endfunction

    function wide_t clamp(wide_t v, int w);
      wide_t hi_lim;
      wide_t lo_lim;
      hi_lim = (wide_t'(1) <<< (w - 1)) - 1;
      lo_lim = -hi_lim - 1;
      if (v > hi_lim) begin
        hit_now = 1'b1;
        return hi_lim;
      end
      if (v < lo_lim) begin
        hit_now = 1'b1;
        return lo_lim;
      end
      return v;
    endfunction

    // The integral is updated first and then used; the rate uses the old error.
    function void take_error(logic signed [DATA_WIDTH-1:0] e);
      wide_t       ew, prevw, dtw, invw, rate, total;
      drive_word_t w;
      hit_now = 1'b0;
      ew = e;
      prevw = prev_err;
      dtw = dt;
      invw = inv;
      integ = ACC_WIDTH'(clamp(wide_t'(integ) + ((ew * dtw) >>> DT_FRAC), ACC_WIDTH));
      rate = clamp(((ew - prevw) * invw) >>> INV_FRAC, 64);
      prev_err = e;
      total = wide_t'(kp) * ew + wide_t'(ki) * wide_t'(integ) + wide_t'(kd) * rate;
      w.drive = OUT_W'(clamp(total >>> OUT_FRAC, DATA_WIDTH));
      w.clip = hit_now;
      if (hit_now) clipped++;
      pending_drive.push_back(w);
    endfunction

    function void match_drive(logic signed [OUT_W-1:0] drive, logic sat);
      drive_word_t w;
      checked++;
      if (pending_drive.size() == 0) begin
        fails++;
        $error("drive_out word %0d arrived with no error word pending", $signed(drive));
        return;
      end
      w = pending_drive.pop_front();
      if (drive !== w.drive) begin
        fails++;
        $error("drive_out: expected %0d, actual %0d", $signed(w.drive), $signed(drive));
      end
      if (sat !== w.clip) begin
        fails++;
        $error("saturated: expected %0b, actual %0b", w.clip, sat);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [DATA_WIDTH-1:0]  error_in = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [OUT_W-1:0]       drive_out;
  logic                          saturated;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_W-1:0]              cfg_data = '0;

  drive_checker drv_chk = new();
  bit           calm = 1'b0;
  int           stall_left = 0;
  int           quiet_cycles = 0;
  int           words_sent = 0;
  int           settings = 0;

  pid_controller_step_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .error_in(error_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .drive_out(drive_out),
    .saturated(saturated),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 12);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) drv_chk.match_drive(drive_out, saturated);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pid_controller_step_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_error(input logic signed [DATA_WIDTH-1:0] e);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    error_in <= e;
    do @(posedge clk); while (in_stall);
    drv_chk.take_error(e);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (drv_chk.pending_drive.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    drv_chk.write_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ki,
                               input logic [CFG_W-1:0] kd, input logic [CFG_W-1:0] dt,
                               input logic [CFG_W-1:0] inv);
    write_reg(REG_PROP, kp);
    write_reg(REG_INTEG, ki);
    write_reg(REG_DERIV, kd);
    write_reg(REG_STEP, dt);
    write_reg(REG_INV, inv);
    settings++;
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_error(
      input logic signed [DATA_WIDTH-1:0] last);
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return $signed($urandom_range(0, 2 * ERR_SPAN)) - ERR_SPAN;
    if (r < 15) return $urandom;
    if (r < 17) return last;
    case ($urandom_range(0, 4))
      0: return ERR_MAX;
      1: return ERR_MIN;
      2: return '0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return GAIN_MAX;
      2: return GAIN_MIN;
      3, 4: return $signed($urandom_range(0, 2 * GAIN_SPAN)) - GAIN_SPAN;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_step(input logic [CFG_W-1:0] dflt);
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2, 3: return dflt;
      4: return $urandom_range(0, 1 << 26);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [DATA_WIDTH-1:0] last_e;
    int                           run_len;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: zero gains, but the integral and last error still move.
    send_error('0);
    send_error(ERR_MAX);
    send_error(ERR_MIN);
    send_error(-1);
    settle();

    // Writes to unused indexes must leave the registers alone.
    for (int k = FIRST_SPARE_IDX; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), $urandom);
    end
    load_settings(GAIN_ONE, GAIN_ONE, 32'h0000_0100, STEP_TIME_RST, INV_STEP_RST);
    send_error(1);
    send_error(-1);
    send_error(GAIN_ONE);
    send_error(ERR_MAX);
    send_error(ERR_MIN);
    send_error('0);
    settle();

    load_settings(GAIN_MAX, GAIN_MIN, GAIN_MAX, '1, '1);
    send_error(ERR_MAX);
    send_error(ERR_MIN);
    send_error(ERR_MAX);
    send_error('0);
    send_error(-1);
    settle();

    // Zero step time freezes the integral; zero reciprocal drops the rate term.
    load_settings(GAIN_MIN, GAIN_ONE, GAIN_ONE, '0, '0);
    repeat (4) send_error($urandom);
    send_error(ERR_MIN);
    last_e = ERR_MIN;

    while (words_sent < TOTAL_WORDS) begin
      settle();
      calm = (words_sent >= TOTAL_WORDS - CALM_WORDS);
      load_settings(pick_gain(), pick_gain(), pick_gain(),
                    pick_step(STEP_TIME_RST), pick_step(INV_STEP_RST));
      run_len = $urandom_range(15, 60);
      repeat (run_len) begin
        last_e = pick_error(last_e);
        send_error(last_e);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d error words under %0d register settings, zero and full-scale steps too.",
             words_sent, settings);
    $display("Checked %0d drive words, %0d of them clipped.", drv_chk.checked, drv_chk.clipped);
    if (drv_chk.fails == 0) begin
      $display("pid_controller_step_top verification clean");
    end else begin
      $display("pid_controller_step_top verification failed");
    end
    $finish;
  end

endmodule
